FILE: sv/fpa_pkg.sv
// shared types, codes and sizes for the fit policy partition allocator
`default_nettype none
package fpa_pkg;

   // storage sizing
   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_WIDTH = 16;
   localparam int ADDR_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

   // fixed field widths
   localparam int TYPE_W   = 2;
   localparam int BLK_W    = 4;
   localparam int VAL_W    = 16;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 5;
   localparam int POL_W    = 2;
   localparam int BCNT_W   = 5;

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_READ  = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_NONE  = 2'd3;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_ALLOC = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_LOAD  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_READ  = 2'd3;

   // placement policies
   localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POL_W-1:0] POL_WORST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   localparam logic [BCNT_W-1:0] BLOCK_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [BLK_W-1:0]  block_index;
      logic [VAL_W-1:0]  size_value;
   } fpa_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BLK_W-1:0]  chosen_block;
      logic [VAL_W-1:0]  remaining_size;
   } fpa_rsp_type;

   // command from the sequencer to the fit unit
   typedef struct packed {
      logic                  clear;
      logic                  sample;
      logic [POL_W-1:0]      policy;
      logic [ADDR_W-1:0]     idx;
      logic [SIZE_WIDTH-1:0] data;
      logic [SIZE_WIDTH-1:0] req_size;
   } fpa_fit_cmd_type;

   // current pick of the fit unit
   typedef struct packed {
      logic                  found;
      logic [ADDR_W-1:0]     idx;
      logic [SIZE_WIDTH-1:0] value;
   } fpa_fit_stat_type;

endpackage
`default_nettype wire

FILE: sv/fit_policy_partition_allocator.sv
// free space table with first, best or worst fit block allocation
//
// Requests come in on req_valid/req_ready with a packed fpa_req_type:
// load writes one block's size, read returns one block's remaining size,
// allocate searches blocks 0 .. block_count-1 under the policy register.
// One response leaves on rsp_valid/rsp_ready per load, read or allocate;
// request kind three is taken and dropped without a response.
// Registers are written through csr_valid/csr_index/csr_wdata; csr_ready
// is always high and writes are expected only while the block is idle.
// The block handles one request at a time and drops req_ready until the
// response is placed in the output register. A load goes straight to the
// finishing step, a read first waits in RDWAIT for the registered ram read
// and an allocate scans blocks up to block_count capped at sixteen; the next
// request can be taken in the cycle in which the response turns valid. The
// scan reads one table entry per cycle through the single ram read port into
// the shared compare unit, then waits for the last compare to drain. A
// response left waiting in the output register does not block the next
// request; the finishing step waits for it.
// Reset sets policy to first fit, block_count to sixteen and marks every
// table entry empty through per-entry valid bits, so no clearing pass.
`default_nettype none
module fit_policy_partition_allocator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire fpa_pkg::fpa_req_type               req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      fpa_pkg::fpa_rsp_type               rsp_data,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [fpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fpa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fpa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RDWAIT = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_DONE   = 4'b1000
   } fpa_state_type;

   fpa_state_type         state_ff, state_in;
   logic [POL_W-1:0]      policy_ff, policy_in;
   logic [BCNT_W-1:0]     block_count_ff, block_count_in;
   logic [TYPE_W-1:0]     kind_ff, kind_in;
   logic [BLK_W-1:0]      idx_ff, idx_in;
   logic [SIZE_WIDTH-1:0] size_ff, size_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      addr_cnt_ff, addr_cnt_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_W-1:0]     samp_idx_ff, samp_idx_in;
   logic [SIZE_WIDTH-1:0] rd_rem_ff, rd_rem_in;
   logic [NUM_BLOCKS-1:0] valid_ff, valid_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fpa_rsp_type           rsp_ff, rsp_in;

   logic                  req_fire;
   logic                  done_fire;
   logic                  issue;
   logic                  idx_ok;
   logic [CNT_W-1:0]      limit_now;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SIZE_WIDTH-1:0] rd_data;
   logic [SIZE_WIDTH-1:0] rd_masked;
   logic [SIZE_WIDTH-1:0] alloc_rem;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [SIZE_WIDTH-1:0] wr_data;
   fpa_fit_cmd_type       fit_cmd;
   fpa_fit_stat_type      fit_stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign issue     = (state_ff == ST_SCAN) && (addr_cnt_ff < limit_ff);
   assign idx_ok    = (32'(idx_ff) < NUM_BLOCKS);
   assign rd_masked = rd_valid_ff ? rd_data : '0;
   assign alloc_rem = fit_stat.value - size_ff;

   // search limit saturates at the table depth
   assign limit_now = (32'(block_count_ff) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                         : CNT_W'(block_count_ff);

   assign rd_addr = (state_ff == ST_IDLE) ? ADDR_W'(req_data.block_index)
                                          : ADDR_W'(addr_cnt_ff);

   // config registers
   always_comb begin
      policy_in      = policy_ff;
      block_count_in = block_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POLICY:      policy_in      = csr_wdata[POL_W-1:0];
            CSR_BLOCK_COUNT: block_count_in = csr_wdata[BCNT_W-1:0];
            default:         ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      size_in     = size_ff;
      limit_in    = limit_ff;
      addr_cnt_in = addr_cnt_ff;
      pend_in     = 1'b0;
      samp_idx_in = samp_idx_ff;
      rd_rem_in   = rd_rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in     = req_data.req_type;
               idx_in      = req_data.block_index;
               size_in     = SIZE_WIDTH'(req_data.size_value);
               limit_in    = limit_now;
               addr_cnt_in = '0;
               case (req_data.req_type)
                  REQ_LOAD:  state_in = ST_DONE;
                  REQ_ALLOC: state_in = ST_SCAN;
                  REQ_READ:  state_in = ST_RDWAIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_RDWAIT: begin
            rd_rem_in = idx_ok ? rd_masked : '0;
            state_in  = ST_DONE;
         end
         ST_SCAN: begin
            // one read issued per cycle, compared the cycle after
            if (issue) begin
               addr_cnt_in = addr_cnt_ff + 1'b1;
               pend_in     = 1'b1;
               samp_idx_in = ADDR_W'(addr_cnt_ff);
            end else if (!pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign fit_cmd.clear    = req_fire;
   assign fit_cmd.sample   = (state_ff == ST_SCAN) && pend_ff;
   assign fit_cmd.policy   = policy_ff;
   assign fit_cmd.idx      = samp_idx_ff;
   assign fit_cmd.data     = rd_masked;
   assign fit_cmd.req_size = size_ff;

   // final step: table write and response
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(idx_ff);
      wr_data = size_ff;
      rsp_in  = rsp_ff;
      case (kind_ff)
         REQ_LOAD: begin
            wr_en                 = done_fire && idx_ok;
            rsp_in.status         = STAT_LOAD;
            rsp_in.chosen_block   = idx_ff;
            rsp_in.remaining_size = idx_ok ? VAL_W'(size_ff) : '0;
         end
         REQ_ALLOC: begin
            wr_addr = fit_stat.idx;
            wr_data = alloc_rem;
            if (fit_stat.found) begin
               wr_en                 = done_fire;
               rsp_in.status         = STAT_ALLOC;
               rsp_in.chosen_block   = BLK_W'(fit_stat.idx);
               rsp_in.remaining_size = VAL_W'(alloc_rem);
            end else begin
               rsp_in.status         = STAT_NOFIT;
               rsp_in.chosen_block   = '0;
               rsp_in.remaining_size = '0;
            end
         end
         default: begin
            rsp_in.status         = STAT_READ;
            rsp_in.chosen_block   = idx_ff;
            rsp_in.remaining_size = VAL_W'(rd_rem_ff);
         end
      endcase
      if (!done_fire) begin
         rsp_in = rsp_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   assign rd_valid_in = valid_ff[rd_addr];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         policy_ff      <= POL_FIRST;
         block_count_ff <= BLOCK_COUNT_RESET;
         pend_ff        <= 1'b0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         policy_ff      <= policy_in;
         block_count_ff <= block_count_in;
         pend_ff        <= pend_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      idx_ff      <= idx_in;
      size_ff     <= size_in;
      limit_ff    <= limit_in;
      addr_cnt_ff <= addr_cnt_in;
      samp_idx_ff <= samp_idx_in;
      rd_rem_ff   <= rd_rem_in;
      rd_valid_ff <= rd_valid_in;
      rsp_ff      <= rsp_in;
   end

   fpa_ram #(
      .WIDTH (SIZE_WIDTH),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fpa_fit_unit u_fit (
      .clock (clock),
      .reset (reset),
      .cmd   (fit_cmd),
      .stat  (fit_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a rejected allocate carries no block and no size
   a_nofit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STAT_NOFIT) |->
         (rsp_data.chosen_block == '0 && rsp_data.remaining_size == '0))
      else $error("not allocated response with nonzero payload");

   // a picked block always lies inside the searched range
   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && kind_ff == REQ_ALLOC && fit_stat.found) |->
         (CNT_W'(fit_stat.idx) < limit_ff))
      else $error("picked block beyond search limit");

   // an accepted request that answers keeps the input closed next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.req_type != REQ_NONE) |=> !req_ready)
      else $error("request taken while previous one in flight");

   // a granted block never ends with more space than it had
   a_alloc_shrinks: assert property (@(posedge clock) disable iff (reset)
      (done_fire && kind_ff == REQ_ALLOC && fit_stat.found) |->
         (alloc_rem <= fit_stat.value))
      else $error("allocation grew a block");

endmodule
`default_nettype wire

FILE: sv/fpa_ram.sv
// generic single write port ram with registered read
`default_nettype none
module fpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/fpa_fit_unit.sv
// shared compare unit that keeps the current pick during a block scan
`default_nettype none
module fpa_fit_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fpa_pkg::fpa_fit_cmd_type cmd,
   output      fpa_pkg::fpa_fit_stat_type stat
);
   import fpa_pkg::*;

   logic                  found_ff, found_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [SIZE_WIDTH-1:0] value_ff, value_in;
   logic                  fits;
   logic                  take;

   always_comb begin
      fits = (cmd.data >= cmd.req_size);
      take = 1'b0;
      if (fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else begin
            case (cmd.policy)
               POL_BEST:  take = (cmd.data < value_ff);
               POL_WORST: take = (cmd.data > value_ff);
               default:   take = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      value_in = value_ff;
      if (cmd.clear) begin
         found_in = 1'b0;
      end else if (cmd.sample && take) begin
         found_in = 1'b1;
         idx_in   = cmd.idx;
         value_in = cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff   <= idx_in;
      value_ff <= value_in;
   end

   assign stat.found = found_ff;
   assign stat.idx   = idx_ff;
   assign stat.value = value_ff;

endmodule
`default_nettype wire

FILE: sim/fpa_fit_checker.sv
`timescale 1ns / 100ps
// response checker for the fit policy allocator: predicts every reply and compares in order
module fpa_fit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  fpa_pkg::fpa_req_type            req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  fpa_pkg::fpa_rsp_type            rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [fpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fpa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              pending_rsps,
   output int                              grant_count,
   output int                              refuse_count
);
   import fpa_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [POL_W-1:0]      cfg_policy;
   logic [BCNT_W-1:0]     cfg_count;
   logic [SIZE_WIDTH-1:0] free_space [NUM_BLOCKS];
   fpa_rsp_type           awaited_q [$];
   int                    mism = 0;
   int                    grants = 0;
   int                    refusals = 0;

   // applies one request to the free space table and returns its response
   function automatic fpa_rsp_type serve_request(input fpa_req_type r);
      fpa_rsp_type           rsp;
      int unsigned           span;
      int unsigned           pick;
      bit                    hit;
      logic [SIZE_WIDTH-1:0] need;
      rsp  = '0;
      hit  = 1'b0;
      pick = 0;
      need = r.size_value;
      case (r.req_type)
         REQ_LOAD: begin
            rsp.status       = STAT_LOAD;
            rsp.chosen_block = r.block_index;
            if (r.block_index < NUM_BLOCKS) begin
               free_space[r.block_index] = need;
               rsp.remaining_size        = need;
            end
         end
         REQ_READ: begin
            rsp.status       = STAT_READ;
            rsp.chosen_block = r.block_index;
            if (r.block_index < NUM_BLOCKS)
               rsp.remaining_size = free_space[r.block_index];
         end
         REQ_ALLOC: begin
            span = (cfg_count > NUM_BLOCKS) ? NUM_BLOCKS : cfg_count;
            for (int j = 0; j < span; j++) begin
               if (free_space[j] >= need) begin
                  if (!hit) begin
                     hit  = 1'b1;
                     pick = j;
                     // unused policy code falls back to first fit
                     if (cfg_policy != POL_BEST && cfg_policy != POL_WORST)
                        break;
                  end else if (cfg_policy == POL_BEST && free_space[j] < free_space[pick]) begin
                     pick = j;
                  end else if (cfg_policy == POL_WORST && free_space[j] > free_space[pick]) begin
                     pick = j;
                  end
               end
            end
            if (hit) begin
               free_space[pick]   = free_space[pick] - need;
               rsp.status         = STAT_ALLOC;
               rsp.chosen_block   = BLK_W'(pick);
               rsp.remaining_size = free_space[pick];
            end else begin
               rsp.status = STAT_NOFIT;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin : watch
      fpa_rsp_type want;
      if (reset) begin
         cfg_policy = POL_FIRST;
         cfg_count  = BLOCK_COUNT_RESET;
         foreach (free_space[j])
            free_space[j] = '0;
         awaited_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLICY:      cfg_policy = csr_wdata[POL_W-1:0];
               CSR_BLOCK_COUNT: cfg_count  = csr_wdata[BCNT_W-1:0];
               default: ;
            endcase
         end
         // responses leave before any request taken on the same edge
         if (rsp_valid && rsp_ready) begin
            if (awaited_q.size() == 0) begin
               if (mism < REPORT_LIMIT)
                  $display("%0t: response with none awaited: status %0d block %0d remaining %0d",
                           $time, rsp_data.status, rsp_data.chosen_block,
                           rsp_data.remaining_size);
               mism++;
            end else begin
               want = awaited_q.pop_front();
               if (want.status == STAT_ALLOC)
                  grants++;
               else if (want.status == STAT_NOFIT)
                  refusals++;
               if (rsp_data.status !== want.status ||
                   rsp_data.chosen_block !== want.chosen_block ||
                   rsp_data.remaining_size !== want.remaining_size) begin
                  if (mism < REPORT_LIMIT)
                     $display("%0t: mismatch: expected status %0d block %0d remaining %0d, %s",
                              $time, want.status, want.chosen_block, want.remaining_size,
                              $sformatf("got status %0d block %0d remaining %0d",
                                        rsp_data.status, rsp_data.chosen_block,
                                        rsp_data.remaining_size));
                  mism++;
               end
            end
         end
         if (req_valid && req_ready && req_data.req_type != REQ_NONE)
            awaited_q.push_back(serve_request(req_data));
      end
      mismatch_count <= mism;
      pending_rsps   <= awaited_q.size();
      grant_count    <= grants;
      refuse_count   <= refusals;
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the fit policy allocator: clock, reset, settings, requests and verdict
module tb_top;
   import fpa_pkg::*;

   localparam logic [POL_W-1:0] POL_SPARE = 2'd3;   // unused code, acts as first fit
   localparam int TOTAL_REQUESTS = 1500;
   localparam int DRAIN_CYCLES   = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   fpa_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   fpa_rsp_type           rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending_rsps;
   int grant_count;
   int refuse_count;
   int sent_count = 0;
   int load_sent = 0;
   int alloc_sent = 0;
   int read_sent = 0;
   int drop_sent = 0;
   int setting_count = 0;
   bit no_gaps = 1'b0;

   fit_policy_partition_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fpa_fit_checker fit_watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (fail_count),
      .pending_rsps   (pending_rsps),
      .grant_count    (grant_count),
      .refuse_count   (refuse_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // block sizes lean toward multiples of 256 so fits often tie
   function automatic logic [VAL_W-1:0] load_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return VAL_W'($urandom_range(0, 15) * 256);
      if (r < 70) return VAL_W'($urandom);
      if (r < 85) return VAL_W'($urandom_range(0, 63));
      if (r < 95) return '1;
      return '0;
   endfunction

   task automatic send_request(input fpa_req_type item);
      int unsigned gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      case (item.req_type)
         REQ_LOAD:  load_sent++;
         REQ_ALLOC: alloc_sent++;
         REQ_READ:  read_sent++;
         default:   drop_sent++;
      endcase
      if (item.req_type != REQ_NONE)
         sent_count++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // all responses in, then time for a dropped request still in flight
   task automatic wait_idle();
      req_valid <= 1'b0;
      // the count seen on the accepting edge does not yet hold that request
      @(posedge clock);
      while (pending_rsps != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : rsp_side
      int unsigned hold;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end else begin
            hold = pick_gap();
            if (hold != 0) begin
               rsp_ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      fpa_req_type           item;
      logic [CSR_DATA_W-1:0] pol_word;
      logic [BCNT_W-1:0]     span;
      int unsigned           r;
      int unsigned           a;
      int                    phase;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_POLICY;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset contents, zero-size request, extremes, ties, dropped kind
      send_request(fpa_req_type'{REQ_READ,  4'd0,  16'h0000});
      send_request(fpa_req_type'{REQ_READ,  4'd15, 16'hFFFF});
      send_request(fpa_req_type'{REQ_ALLOC, 4'd9,  16'h0000});
      send_request(fpa_req_type'{REQ_ALLOC, 4'd0,  16'h0001});
      send_request(fpa_req_type'{REQ_LOAD,  4'd15, 16'hFFFF});
      send_request(fpa_req_type'{REQ_LOAD,  4'd0,  16'h0000});
      send_request(fpa_req_type'{REQ_LOAD,  4'd5,  16'h8000});
      send_request(fpa_req_type'{REQ_LOAD,  4'd10, 16'h8000});
      send_request(fpa_req_type'{REQ_LOAD,  4'd3,  16'h0001});
      send_request(fpa_req_type'{REQ_ALLOC, 4'd0,  16'hFFFF});
      send_request(fpa_req_type'{REQ_ALLOC, 4'd15, 16'h8000});
      send_request(fpa_req_type'{REQ_NONE,  4'd7,  16'hAAAA});
      send_request(fpa_req_type'{REQ_READ,  4'd5,  16'h0000});
      send_request(fpa_req_type'{REQ_READ,  4'd15, 16'h0000});
      send_request(fpa_req_type'{REQ_ALLOC, 4'd0,  16'h0001});
      send_request(fpa_req_type'{REQ_ALLOC, 4'd0,  16'h7FFF});
      send_request(fpa_req_type'{REQ_ALLOC, 4'd0,  16'h0002});
      send_request(fpa_req_type'{REQ_LOAD,  4'd10, 16'h5555});
      send_request(fpa_req_type'{REQ_LOAD,  4'd9,  16'hAAAA});
      send_request(fpa_req_type'{REQ_ALLOC, 4'd6,  16'h0000});
      send_request(fpa_req_type'{REQ_READ,  4'd10, 16'h0000});
      send_request(fpa_req_type'{REQ_READ,  4'd9,  16'h0000});

      phase = 0;
      while (sent_count < TOTAL_REQUESTS) begin
         wait_idle();
         case (phase)
            0: begin pol_word = {3'b000, POL_BEST};   span = BCNT_W'(NUM_BLOCKS); end
            1: begin pol_word = {3'b000, POL_WORST};  span = BCNT_W'(NUM_BLOCKS); end
            2: begin pol_word = {3'b000, POL_SPARE};  span = '1; end
            3: begin pol_word = {3'b000, POL_FIRST};  span = '0; end
            4: begin pol_word = {3'b000, POL_BEST};   span = BCNT_W'(1); end
            5: begin pol_word = {3'b000, POL_WORST};  span = BCNT_W'(NUM_BLOCKS + 1); end
            6: begin pol_word = {3'b111, POL_WORST};  span = BCNT_W'(5); end
            7: begin pol_word = {3'b111, POL_BEST};   span = BCNT_W'(NUM_BLOCKS); end
            default: begin
               pol_word = CSR_DATA_W'($urandom_range(0, 31));
               span = ($urandom_range(0, 1) != 0) ? BCNT_W'(NUM_BLOCKS)
                                                  : BCNT_W'($urandom_range(0, 31));
            end
         endcase
         write_reg(CSR_POLICY, pol_word);
         write_reg(CSR_BLOCK_COUNT, span);
         csr_valid <= 1'b0;
         setting_count++;
         no_gaps = ($urandom_range(0, 3) == 0);

         // refill the whole table, then a random mix that drains it
         for (int b = 0; b < NUM_BLOCKS; b++)
            send_request(fpa_req_type'{REQ_LOAD, BLK_W'(b), load_size()});
         repeat ($urandom_range(90, 120)) begin
            r = $urandom_range(0, 99);
            item.block_index = BLK_W'($urandom);
            if (r < 25) begin
               item.req_type   = REQ_LOAD;
               item.size_value = load_size();
            end else if (r < 75) begin
               item.req_type = REQ_ALLOC;
               a = $urandom_range(0, 99);
               if (a < 35)      item.size_value = VAL_W'($urandom_range(0, 2047));
               else if (a < 55) item.size_value = VAL_W'($urandom_range(0, 63));
               else if (a < 75) item.size_value = VAL_W'($urandom);
               else if (a < 85) item.size_value = '0;
               else if (a < 95) item.size_value = VAL_W'($urandom_range(1, 15) * 256);
               else             item.size_value = '1;
            end else if (r < 95) begin
               item.req_type   = REQ_READ;
               item.size_value = VAL_W'($urandom);
            end else begin
               item.req_type   = REQ_NONE;
               item.size_value = VAL_W'($urandom);
            end
            send_request(item);
         end
         phase++;
      end

      wait_idle();
      $display("covered %0d requests: %0d loads, %0d allocates, %0d reads, %0d dropped",
               sent_count + drop_sent, load_sent, alloc_sent, read_sent, drop_sent);
      $display("%0d register settings; %0d allocates granted, %0d refused",
               setting_count, grant_count, refuse_count);
      if (fail_count == 0 && pending_rsps == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: files.f
sv/fpa_pkg.sv
sv/fpa_ram.sv
sv/fpa_fit_unit.sv
sv/fit_policy_partition_allocator.sv
sim/fpa_fit_checker.sv
sim/tb_top.sv
